FILE: hdl/tse_pkg.sv
// Package for the telegraph shift encoder: beat types, shift codes and the
// fixed character tables. Used by tse_lookup and telegraph_shift_encoder.
`default_nettype none

package tse_pkg;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_RUS  = 2'd1,
        SH_ENG  = 2'd2,
        SH_DIG  = 2'd3
    } shift_t;

    localparam logic [4:0] CODE_RUS   = 5'h00;
    localparam logic [4:0] CODE_ENG   = 5'h1F;
    localparam logic [4:0] CODE_DIG   = 5'h1B;
    localparam logic [4:0] CODE_SPACE = 5'h04;
    localparam logic [4:0] CODE_CR    = 5'h08;
    localparam logic [4:0] CODE_LF    = 5'h02;
    localparam logic [4:0] CODE_QMARK = 5'h19;

    localparam logic [15:0] UC_SPACE   = 16'h0020;
    localparam logic [15:0] UC_CR      = 16'h000D;
    localparam logic [15:0] UC_LF      = 16'h000A;
    localparam logic [15:0] UC_LAT_A   = 16'h0041;
    localparam logic [15:0] UC_LAT_Z   = 16'h005A;
    localparam logic [15:0] UC_CYR_LO  = 16'h0410;
    localparam logic [15:0] UC_DIGIT_0 = 16'h0030;
    localparam logic [15:0] UC_DIGIT_9 = 16'h0039;

    typedef struct packed {
        logic [15:0] char_code;
        logic        end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [4:0] symbol;
        logic       is_shift;
        logic       last;
    } out_beat_t;

    // Result of one character lookup
    typedef struct packed {
        logic [4:0] code;
        shift_t     need;
    } lookup_t;

    function automatic logic [4:0] shift_code(shift_t sh);
        logic [4:0] r;
        unique case (sh)
            SH_RUS:  r = CODE_RUS;
            SH_ENG:  r = CODE_ENG;
            default: r = CODE_DIG;
        endcase
        return r;
    endfunction

    // Latin capitals, index 0 is 'A'
    function automatic logic [4:0] latin_code(logic [4:0] idx);
        logic [4:0] r;
        unique case (idx)
            5'd0:  r = 5'h03;  5'd1:  r = 5'h19;  5'd2:  r = 5'h0E;  5'd3:  r = 5'h09;
            5'd4:  r = 5'h01;  5'd5:  r = 5'h0D;  5'd6:  r = 5'h1A;  5'd7:  r = 5'h14;
            5'd8:  r = 5'h06;  5'd9:  r = 5'h0B;  5'd10: r = 5'h0F;  5'd11: r = 5'h12;
            5'd12: r = 5'h1C;  5'd13: r = 5'h0C;  5'd14: r = 5'h18;  5'd15: r = 5'h16;
            5'd16: r = 5'h17;  5'd17: r = 5'h0A;  5'd18: r = 5'h05;  5'd19: r = 5'h10;
            5'd20: r = 5'h07;  5'd21: r = 5'h1E;  5'd22: r = 5'h13;  5'd23: r = 5'h1D;
            5'd24: r = 5'h15;  5'd25: r = 5'h11;
            default: r = 5'h00;
        endcase
        return r;
    endfunction

    // Cyrillic capitals from U+0410: bits 6:5 shift (none = unmapped), 4:0 code.
    // Che (U+0427) maps to figure '4'.
    function automatic logic [6:0] cyr_entry(logic [4:0] idx);
        logic [6:0] r;
        unique case (idx)
            5'd0:  r = {SH_RUS, 5'h03};  5'd1:  r = {SH_RUS, 5'h19};
            5'd2:  r = {SH_RUS, 5'h13};  5'd3:  r = {SH_RUS, 5'h1A};
            5'd4:  r = {SH_RUS, 5'h09};  5'd5:  r = {SH_RUS, 5'h01};
            5'd6:  r = {SH_RUS, 5'h1E};  5'd7:  r = {SH_RUS, 5'h11};
            5'd8:  r = {SH_RUS, 5'h06};  5'd9:  r = {SH_RUS, 5'h0B};
            5'd10: r = {SH_RUS, 5'h0F};  5'd11: r = {SH_RUS, 5'h12};
            5'd12: r = {SH_RUS, 5'h1C};  5'd13: r = {SH_RUS, 5'h0C};
            5'd14: r = {SH_RUS, 5'h18};  5'd15: r = {SH_RUS, 5'h16};
            5'd16: r = {SH_RUS, 5'h0A};  5'd17: r = {SH_RUS, 5'h05};
            5'd18: r = {SH_RUS, 5'h10};  5'd19: r = {SH_RUS, 5'h07};
            5'd20: r = {SH_RUS, 5'h0D};  5'd21: r = {SH_RUS, 5'h14};
            5'd22: r = {SH_RUS, 5'h0E};  5'd23: r = {SH_DIG, 5'h0A};
            5'd24: r = {SH_DIG, 5'h1A};  5'd25: r = {SH_DIG, 5'h14};
            5'd26: r = {SH_NONE, 5'h00}; 5'd27: r = {SH_RUS, 5'h15};
            5'd28: r = {SH_RUS, 5'h1D};  5'd29: r = {SH_DIG, 5'h0D};
            5'd30: r = {SH_DIG, 5'h0B};  5'd31: r = {SH_RUS, 5'h17};
            default: r = {SH_NONE, 5'h00};
        endcase
        return r;
    endfunction

    // Figures set; bit 5 set when the character is mapped
    function automatic logic [5:0] figure_entry(logic [15:0] c);
        logic [5:0] r;
        if (c >= UC_DIGIT_0 && c <= UC_DIGIT_9)
        begin
            unique case (c[3:0])
                4'd0: r = 6'h36;  4'd1: r = 6'h37;  4'd2: r = 6'h33;  4'd3: r = 6'h21;
                4'd4: r = 6'h2A;  4'd5: r = 6'h30;  4'd6: r = 6'h35;  4'd7: r = 6'h27;
                4'd8: r = 6'h26;  4'd9: r = 6'h38;
                default: r = 6'h00;
            endcase
        end
        else
        begin
            unique case (c)
                16'h002D: r = 6'h23;
                16'h003F: r = 6'h39;
                16'h003A: r = 6'h2E;
                16'h0040: r = 6'h29;
                16'h0028: r = 6'h2F;
                16'h0029: r = 6'h32;
                16'h002E: r = 6'h3C;
                16'h002C: r = 6'h2C;
                16'h0027: r = 6'h25;
                16'h003D: r = 6'h3E;
                16'h002F: r = 6'h3D;
                16'h002B: r = 6'h31;
                default:  r = 6'h00;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tse_lookup.sv
// Character classifier: maps a code point to its telegraph code and the shift
// it needs. Pure combinational; depends on tse_pkg tables.
`default_nettype none

module tse_lookup
    import tse_pkg::*;
(
    input  wire logic [15:0] char_code,
    input  wire shift_t      cur_shift,
    output lookup_t          result
);

    logic [15:0] cyr_off;
    logic [6:0]  cyr_e;
    logic [5:0]  fig_e;
    logic [4:0]  lat_idx;

    assign cyr_off = char_code - UC_CYR_LO;
    assign cyr_e   = cyr_entry(cyr_off[4:0]);
    assign fig_e   = figure_entry(char_code);
    assign lat_idx = char_code[4:0] - 5'd1;

    always_comb
    begin
        priority if (char_code == UC_SPACE)
        begin
            result.code = CODE_SPACE;
            result.need = cur_shift;
        end
        else if (char_code == UC_CR)
        begin
            result.code = CODE_CR;
            result.need = cur_shift;
        end
        else if (char_code == UC_LF)
        begin
            result.code = CODE_LF;
            result.need = cur_shift;
        end
        else if (char_code >= UC_LAT_A && char_code <= UC_LAT_Z)
        begin
            result.code = latin_code(lat_idx);
            result.need = SH_ENG;
        end
        else if (cyr_off[15:5] == 11'd0 && cyr_e[6:5] != SH_NONE)
        begin
            result.code = cyr_e[4:0];
            result.need = shift_t'(cyr_e[6:5]);
        end
        else
        begin
            // unmapped characters go out as '?'
            result.code = fig_e[5] ? fig_e[4:0] : CODE_QMARK;
            result.need = SH_DIG;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/telegraph_shift_encoder.sv
// Top level of the MTK-2 telegraph encoder: input register, lookup and a
// two-entry result stage. Depends on tse_pkg and tse_lookup.
`default_nettype none

// One Unicode character per input beat, one or two 5-bit telegraph codes per
// character on the output: a shift code (is_shift=1) first when the character
// needs a register other than the current one, then the character (last=1).
// A character needing no shift fills the single output register alone; one
// inserting a shift parks its character in the pending register until the
// shift code is taken, while the next character waits in the input register.
// Each character passes the input register, the lookup and the output register.
// After a beat with end_of_message set the remembered shift returns to none.
module telegraph_shift_encoder
    import tse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     char_valid,
    output logic          char_stall,
    input  wire in_beat_t char_beat,
    output logic          sym_valid,
    input  wire logic     sym_stall,
    output out_beat_t     sym_beat
);

    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    logic      pend_valid_reg;
    out_beat_t pend_data_reg;
    shift_t    shift_reg;
    shift_t    shift_next;

    lookup_t   lk;
    logic      load;
    logic      out_take;
    logic      need_shift;

    tse_lookup u_lookup (
        .char_code (in_data_reg.char_code),
        .cur_shift (shift_reg),
        .result    (lk)
    );

    assign out_take   = out_valid_reg && !sym_stall;
    // output slot is free when empty, or when its beat is taken and nothing is queued behind it
    assign load       = in_valid_reg && (!out_valid_reg || (out_take && !pend_valid_reg));
    assign char_stall = in_valid_reg && !load;
    assign need_shift = (lk.need != shift_reg);
    assign shift_next = in_data_reg.end_of_message ? SH_NONE : lk.need;

    assign sym_valid = out_valid_reg;
    assign sym_beat  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            shift_reg      <= SH_NONE;
        end
        else
        begin
            if (!char_stall)
                in_valid_reg <= char_valid;

            if (load)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= need_shift;
                shift_reg      <= shift_next;
            end
            else if (out_take)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
            in_data_reg <= char_beat;

        if (load)
        begin
            if (need_shift)
            begin
                out_data_reg  <= '{symbol: shift_code(lk.need), is_shift: 1'b1, last: 1'b0};
                pend_data_reg <= '{symbol: lk.code, is_shift: 1'b0, last: 1'b1};
            end
            else
            begin
                out_data_reg <= '{symbol: lk.code, is_shift: 1'b0, last: 1'b1};
            end
        end
        else if (out_take && pend_valid_reg)
        begin
            out_data_reg <= pend_data_reg;
        end
    end

endmodule

`default_nettype wire
